// ===== rtl/srgb_to_cielab_top_macros.svh =====
// assertion macros for the srgb to cielab converter
`ifndef SRGB_TO_CIELAB_TOP_MACROS_SVH
`define SRGB_TO_CIELAB_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define S2LAB_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// expression holds at every edge out of reset
`define S2LAB_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`endif

// ===== rtl/s2lab_pkg.sv =====
// shared constants, types and the linearization table for the srgb to cielab converter
package s2lab_pkg;

   localparam int FRAC_BITS = 8;

   localparam int LIN_W   = 25;
   localparam int COEF_W  = 24;
   localparam int PROD_W  = 48;
   localparam int SUM_W   = 49;
   localparam int DIV_W   = 24;
   localparam int RCP_W   = 25;
   localparam int QE_W    = 26;
   localparam int VAL_W   = 25;
   localparam int F_W     = 25;
   localparam int NORM_SHIFT = 22;
   localparam int RCP_SHIFT  = 26;

   localparam int CBRT_BITS = 25;

   // stage counts of each unit
   localparam int XYZ_STAGES  = 6;
   localparam int CBRT_STAGES = 2 + 2 * CBRT_BITS;
   localparam int OUT_STAGES  = 2;
   localparam int PIPE_LATENCY = XYZ_STAGES + CBRT_STAGES + OUT_STAGES;

   typedef logic [2:0][VAL_W-1:0] xyz_type;
   typedef logic [255:0][LIN_W-1:0] lin_rom_type;

   // rgb to xyz matrix, units of 1e-7
   localparam logic [COEF_W-1:0] COEF [3][3] = '{
      '{24'd4124564, 24'd3575761, 24'd1804375},
      '{24'd2126729, 24'd7151522, 24'd721750},
      '{24'd193339,  24'd1191920, 24'd9503041}
   };

   // white point divisors, units of 1e-7
   localparam logic [63:0] DIV_X = 64'd9504700;
   localparam logic [63:0] DIV_Y = 64'd10000000;
   localparam logic [63:0] DIV_Z = 64'd10888300;
   localparam logic [DIV_W-1:0] DIVISOR [3] = '{
      DIV_W'(DIV_X), DIV_W'(DIV_Y), DIV_W'(DIV_Z)
   };
   localparam logic [DIV_W-1:0] DIV_HALF [3] = '{
      DIV_W'(DIV_X / 64'd2), DIV_W'(DIV_Y / 64'd2), DIV_W'(DIV_Z / 64'd2)
   };
   // floor(2^48 / d), never overestimates the quotient
   localparam logic [RCP_W-1:0] RECIP [3] = '{
      RCP_W'((64'd1 << 48) / DIV_X),
      RCP_W'((64'd1 << 48) / DIV_Y),
      RCP_W'((64'd1 << 48) / DIV_Z)
   };

   // companding constants
   localparam logic [VAL_W-1:0] CUBE_THRESH = VAL_W'((64'd8856 << 24) / 64'd1000000);
   localparam int LP_W = 31;
   localparam logic [12:0] LIN_SLOPE = 13'd7787;
   localparam logic [9:0]  LIN_HALF  = 10'd500;
   localparam logic [31:0] MILLI_RCP = 32'(((64'd1 << 41) + 64'd999) / 64'd1000);
   localparam int MILLI_SHIFT = 41;
   localparam logic [F_W-1:0] LIN_OFFSET = F_W'(((64'd4 << 24) + 64'd14) / 64'd29);

   // output formatting
   localparam int OW = 38;
   localparam int OUT_SHIFT = 24 - FRAC_BITS;
   localparam logic signed [OW-1:0] OUT_HALF = OW'(64'd1 << (OUT_SHIFT - 1));
   localparam logic signed [OW-1:0] L_BIAS = OW'(64'd16 << 24);
   localparam logic signed [OW-1:0] L_TOP =
      ((64'd100 << FRAC_BITS) > 64'd32767) ? OW'(32767) : OW'(64'd100 << FRAC_BITS);
   localparam logic signed [OW-1:0] S16_MAX = OW'(32767);
   localparam logic signed [OW-1:0] S16_MIN = -OW'(32768);

   // one entry of the inverse gamma table, q.24
   function automatic logic [LIN_W-1:0] lin_entry(input int unsigned c);
      logic [63:0] cc;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      logic [63:0] p;
      cc = 64'(c);
      if (cc * 64'd100000 <= 64'd1031475) begin
         return LIN_W'((cc * 64'd167772160 + 64'd16473) / 64'd32946);
      end
      t = (((64'd1000 * cc + 64'd14025) << 24) + 64'd134512) / 64'd269025;
      s = (t * t + (64'd1 << 23)) >> 24;
      lo = 64'd0;
      hi = 64'd1 << 24;
      while (lo < hi) begin
         mid = (lo + hi + 64'd1) >> 1;
         p = (mid * mid) >> 24;
         p = (p * mid) >> 24;
         p = (p * mid) >> 24;
         p = (p * mid) >> 24;
         if (p <= s) begin
            lo = mid;
         end else begin
            hi = mid - 64'd1;
         end
      end
      return LIN_W'((s * lo + (64'd1 << 23)) >> 24);
   endfunction

   function automatic lin_rom_type lin_build();
      lin_rom_type rom;
      for (int c = 0; c < 256; c++) begin
         rom[c] = lin_entry(c);
      end
      return rom;
   endfunction

   localparam lin_rom_type LIN_ROM = lin_build();

endpackage

// ===== rtl/s2lab_xyz.sv =====
// linearization lookup, rgb to xyz matrix and white point division
module s2lab_xyz (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [23:0]             in_pixel,
   output logic                    out_valid,
   output s2lab_pkg::xyz_type      out_xyz
);

   localparam int LIN_W  = s2lab_pkg::LIN_W;
   localparam int PROD_W = s2lab_pkg::PROD_W;
   localparam int SUM_W  = s2lab_pkg::SUM_W;
   localparam int QE_W   = s2lab_pkg::QE_W;
   localparam int VAL_W  = s2lab_pkg::VAL_W;
   localparam int NH_W   = SUM_W - s2lab_pkg::NORM_SHIFT;
   localparam int QP_W   = NH_W + s2lab_pkg::RCP_W;
   localparam int QD_W   = QE_W + s2lab_pkg::DIV_W;

   logic [s2lab_pkg::XYZ_STAGES-1:0] vld_ff;
   logic [s2lab_pkg::XYZ_STAGES-1:0] vld_in;

   logic [LIN_W-1:0]  lin_ff  [3];
   logic [LIN_W-1:0]  lin_in  [3];
   logic [PROD_W-1:0] prod_ff [3][3];
   logic [PROD_W-1:0] prod_in [3][3];
   logic [SUM_W-1:0]  num_ff  [3];
   logic [SUM_W-1:0]  num_in  [3];
   logic [SUM_W-1:0]  num2_ff [3];
   logic [QE_W-1:0]   qe_ff   [3];
   logic [QE_W-1:0]   qe_in   [3];
   logic [QE_W-1:0]   qe2_ff  [3];
   logic [QE_W-1:0]   rem_ff  [3];
   logic [QE_W-1:0]   rem_in  [3];
   logic [VAL_W-1:0]  quo_ff  [3];
   logic [VAL_W-1:0]  quo_in  [3];

   logic [QP_W-1:0] qprod [3];
   logic [QD_W-1:0] qdprod [3];
   logic [QD_W-1:0] rwide [3];
   logic [QE_W-1:0] qsum [3];

   assign vld_in = {vld_ff[s2lab_pkg::XYZ_STAGES-2:0], in_valid};

   always_comb begin
      lin_in[0] = s2lab_pkg::LIN_ROM[in_pixel[23:16]];
      lin_in[1] = s2lab_pkg::LIN_ROM[in_pixel[15:8]];
      lin_in[2] = s2lab_pkg::LIN_ROM[in_pixel[7:0]];
      for (int ch = 0; ch < 3; ch++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[ch][j] = PROD_W'(s2lab_pkg::COEF[ch][j]) * PROD_W'(lin_ff[j]);
         end
         // rounding half added up front
         num_in[ch] = SUM_W'(prod_ff[ch][0]) + SUM_W'(prod_ff[ch][1])
                    + SUM_W'(prod_ff[ch][2]) + SUM_W'(s2lab_pkg::DIV_HALF[ch]);
         // quotient estimate, low by at most two
         qprod[ch] = QP_W'(num_ff[ch][SUM_W-1:s2lab_pkg::NORM_SHIFT])
                   * QP_W'(s2lab_pkg::RECIP[ch]);
         qe_in[ch] = QE_W'(qprod[ch] >> s2lab_pkg::RCP_SHIFT);
         qdprod[ch] = QD_W'(qe_ff[ch]) * QD_W'(s2lab_pkg::DIVISOR[ch]);
         rwide[ch] = QD_W'(num2_ff[ch]) - qdprod[ch];
         rem_in[ch] = rwide[ch][QE_W-1:0];
         qsum[ch] = qe2_ff[ch]
                  + QE_W'(rem_ff[ch] >= QE_W'(s2lab_pkg::DIVISOR[ch]))
                  + QE_W'(rem_ff[ch] >= (QE_W'(s2lab_pkg::DIVISOR[ch]) << 1));
         quo_in[ch] = qsum[ch][VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < 3; ch++) begin
         lin_ff[ch] <= lin_in[ch];
         for (int j = 0; j < 3; j++) begin
            prod_ff[ch][j] <= prod_in[ch][j];
         end
         num_ff[ch]  <= num_in[ch];
         num2_ff[ch] <= num_ff[ch];
         qe_ff[ch]   <= qe_in[ch];
         qe2_ff[ch]  <= qe_ff[ch];
         rem_ff[ch]  <= rem_in[ch];
         quo_ff[ch]  <= quo_in[ch];
      end
   end

   assign out_valid = vld_ff[s2lab_pkg::XYZ_STAGES-1];
   assign out_xyz   = {quo_ff[2], quo_ff[1], quo_ff[0]};

endmodule

// ===== rtl/s2lab_cbrt.sv =====
// cielab companding: bit-serial pipelined cube root with linear segment below threshold
module s2lab_cbrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [s2lab_pkg::VAL_W-1:0]    in_value,
   output logic                           out_valid,
   output logic [s2lab_pkg::F_W-1:0]      out_f
);

   localparam int NB    = s2lab_pkg::CBRT_BITS;
   localparam int F_W   = s2lab_pkg::F_W;
   localparam int VAL_W = s2lab_pkg::VAL_W;
   localparam int SQ_W  = 2 * F_W;
   localparam int HI_W  = SQ_W - 24;
   localparam int CP_W  = HI_W + F_W;
   localparam int CMP_W = CP_W - 24;
   localparam int LP_W  = s2lab_pkg::LP_W;
   localparam int LM_W  = LP_W + 32;

   typedef struct packed {
      logic [VAL_W-1:0] v;
      logic [F_W-1:0]   lin;
      logic             cube;
   } side_type;

   // prep stages
   logic             v0_vld_ff;
   logic [VAL_W-1:0] v0_ff;
   logic [LP_W-1:0]  lp_ff;
   logic [LP_W-1:0]  lp_in;
   logic [37:0]      lp_wide;
   logic             s1_vld_ff;
   side_type         s1_ff;
   side_type         s1_in;
   logic [LM_W-1:0]  lm_wide;

   // per bit: try stage then accept stage
   logic             a_vld_ff  [NB];
   side_type         a_side_ff [NB];
   logic [F_W-1:0]   a_q_ff    [NB];
   logic [SQ_W-1:0]  a_sq_ff   [NB];
   logic [F_W-1:0]   a_cand_ff [NB];
   logic [SQ_W-1:0]  a_csq_ff  [NB];
   logic [F_W-1:0]   a_cand_in [NB];
   logic [SQ_W-1:0]  a_csq_in  [NB];
   logic             a_vld_in  [NB];
   side_type         a_side_in [NB];
   logic [F_W-1:0]   a_q_in    [NB];
   logic [SQ_W-1:0]  a_sq_in   [NB];

   logic             b_vld_ff  [NB];
   side_type         b_side_ff [NB];
   logic [F_W-1:0]   b_q_ff    [NB];
   logic [SQ_W-1:0]  b_sq_ff   [NB];
   logic [F_W-1:0]   b_q_in    [NB];
   logic [SQ_W-1:0]  b_sq_in   [NB];

   logic [CP_W-1:0]  cube_prod [NB];
   logic             fits      [NB];

   always_comb begin
      lp_wide = 38'(s2lab_pkg::LIN_SLOPE) * 38'(in_value) + 38'(s2lab_pkg::LIN_HALF);
      lp_in   = lp_wide[LP_W-1:0];
      lm_wide = LM_W'(lp_ff) * LM_W'(s2lab_pkg::MILLI_RCP);
      s1_in.v    = v0_ff;
      s1_in.cube = (v0_ff > s2lab_pkg::CUBE_THRESH);
      s1_in.lin  = F_W'(lm_wide >> s2lab_pkg::MILLI_SHIFT) + s2lab_pkg::LIN_OFFSET;

      // first bit starts from an empty root
      a_vld_in[0]  = s1_vld_ff;
      a_side_in[0] = s1_ff;
      a_q_in[0]    = '0;
      a_sq_in[0]   = '0;
      for (int i = 1; i < NB; i++) begin
         a_vld_in[i]  = b_vld_ff[i-1];
         a_side_in[i] = b_side_ff[i-1];
         a_q_in[i]    = b_q_ff[i-1];
         a_sq_in[i]   = b_sq_ff[i-1];
      end

      for (int i = 0; i < NB; i++) begin
         // (q + 2^k)^2 by shift and add, q holds no bits at or below k
         a_cand_in[i] = a_q_in[i] | (F_W'(1) << (NB - 1 - i));
         a_csq_in[i]  = a_sq_in[i] + (SQ_W'(a_q_in[i]) << (NB - i))
                      + (SQ_W'(1) << (2 * (NB - 1 - i)));

         cube_prod[i] = CP_W'(a_csq_ff[i][SQ_W-1:24]) * CP_W'(a_cand_ff[i]);
         fits[i]      = (cube_prod[i][CP_W-1:24] <= CMP_W'(a_side_ff[i].v));
         b_q_in[i]    = fits[i] ? a_cand_ff[i] : a_q_ff[i];
         b_sq_in[i]   = fits[i] ? a_csq_ff[i]  : a_sq_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         for (int i = 0; i < NB; i++) begin
            a_vld_ff[i] <= 1'b0;
            b_vld_ff[i] <= 1'b0;
         end
      end else begin
         v0_vld_ff <= in_valid;
         s1_vld_ff <= v0_vld_ff;
         for (int i = 0; i < NB; i++) begin
            a_vld_ff[i] <= a_vld_in[i];
            b_vld_ff[i] <= a_vld_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      v0_ff <= in_value;
      lp_ff <= lp_in;
      s1_ff <= s1_in;
      for (int i = 0; i < NB; i++) begin
         a_side_ff[i] <= a_side_in[i];
         a_q_ff[i]    <= a_q_in[i];
         a_sq_ff[i]   <= a_sq_in[i];
         a_cand_ff[i] <= a_cand_in[i];
         a_csq_ff[i]  <= a_csq_in[i];
         b_side_ff[i] <= a_side_ff[i];
         b_q_ff[i]    <= b_q_in[i];
         b_sq_ff[i]   <= b_sq_in[i];
      end
   end

   assign out_valid = b_vld_ff[NB-1];
   assign out_f     = b_side_ff[NB-1].cube ? b_q_ff[NB-1] : b_side_ff[NB-1].lin;

endmodule

// ===== rtl/s2lab_out.sv =====
// forms l, a and b, rounds to the output fraction and saturates
module s2lab_out (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [s2lab_pkg::F_W-1:0]   in_fx,
   input  logic [s2lab_pkg::F_W-1:0]   in_fy,
   input  logic [s2lab_pkg::F_W-1:0]   in_fz,
   output logic                        out_valid,
   output logic [14:0]                 out_lightness,
   output logic signed [15:0]          out_green_red,
   output logic signed [15:0]          out_blue_yellow
);

   localparam int OW = s2lab_pkg::OW;
   localparam logic signed [OW-1:0] K116 = OW'(116);
   localparam logic signed [OW-1:0] K500 = OW'(500);
   localparam logic signed [OW-1:0] K200 = OW'(200);

   logic [1:0] vld_ff;

   logic signed [OW-1:0] sfx;
   logic signed [OW-1:0] sfy;
   logic signed [OW-1:0] sfz;
   logic signed [OW-1:0] lm_ff;
   logic signed [OW-1:0] lm_in;
   logic signed [OW-1:0] am_ff;
   logic signed [OW-1:0] am_in;
   logic signed [OW-1:0] bm_ff;
   logic signed [OW-1:0] bm_in;
   logic signed [OW-1:0] ls;
   logic signed [OW-1:0] as;
   logic signed [OW-1:0] bs;

   logic [14:0]        l_ff;
   logic [14:0]        l_in;
   logic signed [15:0] a_ff;
   logic signed [15:0] a_in;
   logic signed [15:0] b_ff;
   logic signed [15:0] b_in;

   always_comb begin
      sfx = $signed(OW'(in_fx));
      sfy = $signed(OW'(in_fy));
      sfz = $signed(OW'(in_fz));
      lm_in = sfy * K116 - s2lab_pkg::L_BIAS + s2lab_pkg::OUT_HALF;
      am_in = (sfx - sfy) * K500 + s2lab_pkg::OUT_HALF;
      bm_in = (sfy - sfz) * K200 + s2lab_pkg::OUT_HALF;

      // arithmetic shift gives floor division
      ls = lm_ff >>> s2lab_pkg::OUT_SHIFT;
      as = am_ff >>> s2lab_pkg::OUT_SHIFT;
      bs = bm_ff >>> s2lab_pkg::OUT_SHIFT;

      priority if (ls < 0) begin
         l_in = '0;
      end else if (ls > s2lab_pkg::L_TOP) begin
         l_in = s2lab_pkg::L_TOP[14:0];
      end else begin
         l_in = ls[14:0];
      end

      priority if (as < s2lab_pkg::S16_MIN) begin
         a_in = s2lab_pkg::S16_MIN[15:0];
      end else if (as > s2lab_pkg::S16_MAX) begin
         a_in = s2lab_pkg::S16_MAX[15:0];
      end else begin
         a_in = as[15:0];
      end

      priority if (bs < s2lab_pkg::S16_MIN) begin
         b_in = s2lab_pkg::S16_MIN[15:0];
      end else if (bs > s2lab_pkg::S16_MAX) begin
         b_in = s2lab_pkg::S16_MAX[15:0];
      end else begin
         b_in = bs[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      lm_ff <= lm_in;
      am_ff <= am_in;
      bm_ff <= bm_in;
      l_ff  <= l_in;
      a_ff  <= a_in;
      b_ff  <= b_in;
   end

   assign out_valid       = vld_ff[1];
   assign out_lightness   = l_ff;
   assign out_green_red   = a_ff;
   assign out_blue_yellow = b_ff;

endmodule

// ===== rtl/srgb_to_cielab_top.sv =====
// top level of the srgb to cielab (d65) pixel converter
//
//   channel   ports                                   handshake
//   request   req_pixel_rgb                           start high, busy low
//   response  rsp_lightness, rsp_green_red_axis,      rsp_valid, one cycle,
//             rsp_blue_yellow_axis                    no back-pressure
//
// one transaction per clock, each passing in order through the matrix unit, the
// cube root (two prep stages, then two per result bit) and output formatting
// busy stays low: every stage advances every cycle and the receiver cannot stall
// synchronous reset clears only the valid bits; data registers run free
`include "srgb_to_cielab_top_macros.svh"

module srgb_to_cielab_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [23:0]        req_pixel_rgb,
   output logic               rsp_valid,
   output logic [14:0]        rsp_lightness,
   output logic signed [15:0] rsp_green_red_axis,
   output logic signed [15:0] rsp_blue_yellow_axis
);

   logic                         xyz_valid;
   s2lab_pkg::xyz_type           xyz;
   logic [2:0]                   f_valid;
   logic [s2lab_pkg::F_W-1:0]    f_val [3];

   // nothing ever holds the pipeline
   assign busy = 1'b0;

   // linear rgb through the matrix, normalized by the white point
   s2lab_xyz u_xyz (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_pixel  (req_pixel_rgb),
      .out_valid (xyz_valid),
      .out_xyz   (xyz)
   );

   // one companding pipe per axis
   for (genvar ch = 0; ch < 3; ch++) begin : g_cbrt
      s2lab_cbrt u_cbrt (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (xyz_valid),
         .in_value  (xyz[ch]),
         .out_valid (f_valid[ch]),
         .out_f     (f_val[ch])
      );
   end

   s2lab_out u_out (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (f_valid[1]),
      .in_fx           (f_val[0]),
      .in_fy           (f_val[1]),
      .in_fz           (f_val[2]),
      .out_valid       (rsp_valid),
      .out_lightness   (rsp_lightness),
      .out_green_red   (rsp_green_red_axis),
      .out_blue_yellow (rsp_blue_yellow_axis)
   );

   // a result only ever comes from a matching earlier request
   `S2LAB_ASSERT_IMPLY(a_rsp_from_req, clock, reset, rsp_valid, $past(start, s2lab_pkg::PIPE_LATENCY), "response without matching request")
   // the three companding pipes stay in lockstep
   `S2LAB_ASSERT_ALWAYS(a_axis_lockstep, clock, reset, (f_valid == 3'b000) || (f_valid == 3'b111), "companding pipes out of step")
   // lightness saturation holds
   `S2LAB_ASSERT_IMPLY(a_light_range, clock, reset, rsp_valid, ($signed({1'b0, rsp_lightness}) <= s2lab_pkg::L_TOP), "lightness above its ceiling")

endmodule
